### hw/rtl/plru_pkg.sv
package plru_pkg;

	// geometry
	localparam int SETS       = 2048;
	localparam int WAYS       = 16;
	localparam int PC_ENTRIES = 1024;
	localparam int SET_W      = $clog2(SETS);
	localparam int WAY_W      = $clog2(WAYS);
	localparam int PC_W       = $clog2(PC_ENTRIES);
	localparam int POS_W      = WAY_W;
	localparam int CLR_W      = (SET_W > PC_W) ? SET_W : PC_W;
	localparam int CLR_LEN    = (SETS > PC_ENTRIES) ? SETS : PC_ENTRIES;

	// field widths
	localparam int ADDR_W  = 64;
	localparam int CNT_W   = 16;
	localparam int EPOCH_W = 32;

	// operation codes
	localparam logic OP_VICTIM = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_REUSE_TH  = 2'd0;
	localparam logic [1:0] REG_STRIDE_TH = 2'd1;
	localparam logic [1:0] REG_EPOCH_LEN = 2'd2;

	// configuration reset values
	localparam logic [CNT_W-1:0]   REUSE_TH_RST  = 16'd2;
	localparam logic [CNT_W-1:0]   STRIDE_TH_RST = 16'd2;
	localparam logic [EPOCH_W-1:0] EPOCH_LEN_RST = 32'd100000;
	localparam logic [CNT_W-1:0]   REUSE_MAX     = 16'hFFFF;

	typedef struct packed {
		logic              op;
		logic [SET_W-1:0]  set_index;
		logic [WAY_W-1:0]  way;
		logic [PC_W-1:0]   pc_index;
		logic [ADDR_W-1:0] address;
		logic              hit;
	} in_t;

	typedef struct packed {
		logic [WAY_W-1:0] victim_way;
		logic [WAY_W-1:0] temporal_ways;
	} out_t;

	typedef struct packed {
		logic [CNT_W-1:0]   reuse_th;
		logic [CNT_W-1:0]   stride_th;
		logic [EPOCH_W-1:0] epoch_len;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  reuse;
		logic [CNT_W-1:0]  stride;
		logic [ADDR_W-1:0] last;
	} pc_ent_t;

	typedef logic [WAYS-1:0][POS_W-1:0] row_t;

	// controller to datapath
	typedef struct packed {
		logic             capture;
		logic             commit;
		logic             clear;
		logic [CLR_W-1:0] clear_idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_victim;
		logic out_busy;
	} stat_t;

	// recency row after reset: each way's position equals its index
	function automatic row_t reset_row();
		row_t r;
		for (int w = 0; w < WAYS; w++) begin
			r[w] = POS_W'(w);
		end
		return r;
	endfunction

endpackage

### hw/rtl/pc_classified_partitioned_lru_unit.sv
// Partitioned LRU replacement engine with per-PC reuse/stride classification.
// In the accept cycle a transaction reads the PC entry and the set's recency
// row from registered-read memories; in the execute state the unit classifies,
// searches or promotes, and writes both back. A victim request holds in the
// execute state while a previous result is still stalled at the output. After
// reset a clearing pass initializes both memories; no input transaction is
// accepted until it ends, while configuration writes are taken.
module pc_classified_partitioned_lru_unit import plru_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reuse_th  <= REUSE_TH_RST;
			cfg_q.stride_th <= STRIDE_TH_RST;
			cfg_q.epoch_len <= EPOCH_LEN_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_REUSE_TH:  cfg_q.reuse_th  <= pwdata[CNT_W-1:0];
				REG_STRIDE_TH: cfg_q.stride_th <= pwdata[CNT_W-1:0];
				REG_EPOCH_LEN: cfg_q.epoch_len <= pwdata;
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_REUSE_TH:  prdata = {16'd0, cfg_q.reuse_th};
			REG_STRIDE_TH: prdata = {16'd0, cfg_q.stride_th};
			REG_EPOCH_LEN: prdata = cfg_q.epoch_len;
			default:       prdata = '0;
		endcase
	end

	plru_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.stat(stat), .cmd(cmd)
	);

	plru_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .cfg(cfg_q),
		.in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_item)
	);

endmodule

### hw/rtl/plru_ram.sv
module plru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/plru_ctrl.sv
module plru_ctrl import plru_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t           state_q;
	logic [CLR_W-1:0] clr_q;
	logic             go;

	// execute unless a result must wait for the output slot
	assign go = (state_q == ST_EXEC) && !(stat.is_victim && stat.out_busy);

	assign in_stall      = (state_q != ST_IDLE);
	assign cmd.capture   = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit    = go;
	assign cmd.clear     = (state_q == ST_CLEAR);
	assign cmd.clear_idx = clr_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_LEN - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

### hw/rtl/plru_dp.sv
module plru_dp import plru_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output stat_t stat,
	input  cfg_t  cfg,
	input  in_t   in_item,
	output logic  out_valid,
	input  logic  out_stall,
	output out_t  out_item
);

	in_t              item_q;
	logic [WAY_W-1:0] boundary_q;
	logic [EPOCH_W-1:0] epoch_q, thit_q, shit_q;
	logic             out_valid_q;
	out_t             out_q;

	pc_ent_t          pc_rd, pc_wr;
	row_t             row_rd, row_wr;
	logic [PC_W-1:0]  pc_raddr, pc_waddr;
	logic [SET_W-1:0] set_raddr, set_waddr;
	logic             pc_we, row_we;

	logic             is_victim;
	logic [CNT_W-1:0] stride_new, reuse_new;
	logic             spatial;
	logic [WAYS-1:0]  in_region;
	logic [WAY_W-1:0] victim;
	logic [EPOCH_W-1:0] epoch_nx, thit_nx, shit_nx;

	assign is_victim = (item_q.op == OP_VICTIM);
	assign stat.is_victim = is_victim;
	assign stat.out_busy  = out_valid_q && out_stall;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
	end

	// read addresses follow the incoming transaction while it is accepted
	assign pc_raddr  = cmd.capture ? in_item.pc_index  : item_q.pc_index;
	assign set_raddr = cmd.capture ? in_item.set_index : item_q.set_index;

	plru_ram #(.WIDTH($bits(pc_ent_t)), .DEPTH(PC_ENTRIES)) u_pc_ram (
		.clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wr),
		.raddr(pc_raddr), .rdata(pc_rd)
	);

	plru_ram #(.WIDTH($bits(row_t)), .DEPTH(SETS)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(set_waddr), .wdata(row_wr),
		.raddr(set_raddr), .rdata(row_rd)
	);

	// stride and reuse counter updates
	always_comb begin
		if (pc_rd.last != '0 && item_q.address != pc_rd.last) begin
			stride_new = pc_rd.stride + 1'b1;
		end else begin
			stride_new = CNT_W'(1);
		end
		if (item_q.hit) begin
			reuse_new = (pc_rd.reuse < REUSE_MAX) ? pc_rd.reuse + 1'b1 : pc_rd.reuse;
		end else begin
			reuse_new = (pc_rd.reuse > '0) ? pc_rd.reuse - 1'b1 : pc_rd.reuse;
		end
	end

	// classification: victim requests see the freshly updated stride count
	always_comb begin
		logic [CNT_W-1:0] s;
		s = is_victim ? stride_new : pc_rd.stride;
		spatial = !(pc_rd.reuse >= cfg.reuse_th) && (s >= cfg.stride_th);
		for (int w = 0; w < WAYS; w++) begin
			in_region[w] = spatial ? (WAY_W'(w) >= boundary_q) : (WAY_W'(w) < boundary_q);
		end
	end

	// lru search: max position in region, lowest index wins ties
	always_comb begin
		logic [POS_W:0]   key [WAY_W+1][WAYS];
		logic [WAY_W-1:0] idx [WAY_W+1][WAYS];
		for (int w = 0; w < WAYS; w++) begin
			key[0][w] = {in_region[w], row_rd[w]};
			idx[0][w] = WAY_W'(w);
		end
		for (int l = 1; l <= WAY_W; l++) begin
			for (int w = 0; w < WAYS; w++) begin
				key[l][w] = '0;
				idx[l][w] = '0;
			end
			for (int w = 0; w < (WAYS >> l); w++) begin
				if (key[l-1][2*w+1] > key[l-1][2*w]) begin
					key[l][w] = key[l-1][2*w+1];
					idx[l][w] = idx[l-1][2*w+1];
				end else begin
					key[l][w] = key[l-1][2*w];
					idx[l][w] = idx[l-1][2*w];
				end
			end
		end
		victim = idx[WAY_W][0];
	end

	// promotion within the region
	always_comb begin
		logic [POS_W-1:0] old;
		old = row_rd[item_q.way];
		for (int w = 0; w < WAYS; w++) begin
			row_wr[w] = (in_region[w] && row_rd[w] < old) ? row_rd[w] + 1'b1 : row_rd[w];
		end
		row_wr[item_q.way] = '0;
		if (cmd.clear) begin
			row_wr = reset_row();
		end
	end

	// memory write-back, or the clearing pass after reset
	always_comb begin
		pc_wr.reuse  = is_victim ? pc_rd.reuse : reuse_new;
		pc_wr.stride = is_victim ? stride_new : pc_rd.stride;
		pc_wr.last   = is_victim ? item_q.address : pc_rd.last;
		if (cmd.clear) begin
			pc_wr = '0;
		end
		pc_we     = cmd.commit || (cmd.clear && cmd.clear_idx < CLR_W'(PC_ENTRIES));
		pc_waddr  = cmd.clear ? cmd.clear_idx[PC_W-1:0] : item_q.pc_index;
		row_we    = (cmd.commit && !is_victim && ({1'b0, item_q.way} < (WAY_W+1)'(WAYS)))
		            || cmd.clear;
		set_waddr = cmd.clear ? cmd.clear_idx[SET_W-1:0] : item_q.set_index;
	end

	// epoch counters
	always_comb begin
		epoch_nx = epoch_q + 1'b1;
		thit_nx  = thit_q + EPOCH_W'(item_q.hit && !spatial);
		shit_nx  = shit_q + EPOCH_W'(item_q.hit && spatial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boundary_q <= WAY_W'(WAYS / 2);
			epoch_q    <= '0;
			thit_q     <= '0;
			shit_q     <= '0;
		end else if (cmd.commit && !is_victim) begin
			if (epoch_nx >= cfg.epoch_len) begin
				if (thit_nx > shit_nx && boundary_q < WAY_W'(WAYS - 1)) begin
					boundary_q <= boundary_q + 1'b1;
				end else if (shit_nx > thit_nx && boundary_q > WAY_W'(1)) begin
					boundary_q <= boundary_q - 1'b1;
				end
				epoch_q <= '0;
				thit_q  <= '0;
				shit_q  <= '0;
			end else begin
				epoch_q <= epoch_nx;
				thit_q  <= thit_nx;
				shit_q  <= shit_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && is_victim) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && is_victim) begin
			out_q.victim_way    <= victim;
			out_q.temporal_ways <= boundary_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
